// ===== src/scwg_pkg.sv =====
// Package for the sine/cosine wave generator: constants, CORDIC angle table, register codes.
`default_nettype none

package scwg_pkg;

  localparam int PhaseBitsDef  = 32;
  localparam int SampleBitsDef = 16;

  localparam int CountW      = 24;
  localparam int AngleW      = 32;
  localparam int CordicSteps = 28;
  localparam int CordicXW    = 32;
  localparam int CordicZW    = 33;
  localparam int CordicFrac  = 29;
  localparam int CordicX0    = 326016436;

  localparam logic [AngleW-1:0] QuarterTurn = 32'h4000_0000;

  // atan(2^-i) in units of 2^-32 turn
  localparam int AtanTurns [CordicSteps] = '{
    536870912, 316933406, 167458907, 85004757, 42667331, 21354465,
    10679841, 5340245, 2670163, 1335087, 667544, 333772, 166886,
    83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
    81, 41, 20, 10, 5
  };

  localparam int RegIdxW = 3;

  typedef enum logic [RegIdxW-1:0] {
    RegAmplitude   = 3'd0,
    RegPhaseStep   = 3'd1,
    RegPhaseOffset = 3'd2,
    RegSampleCount = 3'd3,
    RegWaveSelect  = 3'd4
  } reg_idx_e;

endpackage

`default_nettype wire

// ===== src/sine_cosine_wave_generator.sv =====
// Top level of the sine/cosine wave generator: sequencer, pipelined CORDIC, scaling, APB registers.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+------------------------------
//   in       | in_valid_i / in_ready_o    | restart_i
//   out      | out_valid_o / out_ready_i  | sample_o, last_o
//   config   | psel, penable, pwrite      | paddr, pwdata, prdata
//
// One transaction per clock while in_ready_o is high; a sample passes through the
// phase stage, fold stage, 28 CORDIC stages, multiply stage and round/saturate stage.
// rst_ni clears the registers to their defaults and empties the pipeline.
// Stages advance independently, so input is taken while bubbles remain in the
// pipeline; in_ready_o drops only when every stage is full and out is stalled.
// A transaction that produces no sample takes no pipeline slot.
`default_nettype none

module sine_cosine_wave_generator #(
  parameter int  PHASE_BITS  = scwg_pkg::PhaseBitsDef,
  parameter int  SAMPLE_BITS = scwg_pkg::SampleBitsDef,
  localparam int DataW       = (PHASE_BITS > 32) ? 64 : 32,
  localparam int AlignW      = (PHASE_BITS > 32) ? 3 : 2,
  localparam int AddrW       = AlignW + scwg_pkg::RegIdxW
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,

  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic                   restart_i,

  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output logic signed [SAMPLE_BITS-1:0] sample_o,
  output logic                        last_o,

  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [AddrW-1:0]       paddr,
  input  wire logic [DataW-1:0]       pwdata,
  output logic [DataW-1:0]            prdata,
  output logic                        pready
);

  import scwg_pkg::*;

  localparam int XW = CordicXW;
  localparam int ZW = CordicZW;
  localparam int PW = SAMPLE_BITS + XW + 1;

  localparam logic signed [PW-1:0] RoundHalf = PW'(64'sd1 <<< (CordicFrac - 1));
  localparam logic signed [PW-1:0] SatHi     = PW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [PW-1:0] SatLo     = -SatHi - PW'(1);

  // configuration registers
  logic signed [SAMPLE_BITS-1:0] amp_q;
  logic [PHASE_BITS-1:0]         step_q, off_q;
  logic [CountW-1:0]             cnt_q;
  logic                          wave_q;

  logic [RegIdxW-1:0] cfg_idx;
  logic               cfg_we;

  assign cfg_idx = paddr[AlignW +: RegIdxW];
  assign cfg_we  = psel & penable & pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      amp_q  <= {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      step_q <= '0;
      off_q  <= '0;
      cnt_q  <= '0;
      wave_q <= 1'b0;
    end else if (cfg_we) begin
      unique case (reg_idx_e'(cfg_idx))
        RegAmplitude:   amp_q  <= pwdata[SAMPLE_BITS-1:0];
        RegPhaseStep:   step_q <= pwdata[PHASE_BITS-1:0];
        RegPhaseOffset: off_q  <= pwdata[PHASE_BITS-1:0];
        RegSampleCount: cnt_q  <= pwdata[CountW-1:0];
        RegWaveSelect:  wave_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx_e'(cfg_idx))
      RegAmplitude:   prdata = DataW'(unsigned'(amp_q));
      RegPhaseStep:   prdata = DataW'(step_q);
      RegPhaseOffset: prdata = DataW'(off_q);
      RegSampleCount: prdata = DataW'(cnt_q);
      RegWaveSelect:  prdata = DataW'(wave_q);
      default:        prdata = '0;
    endcase
  end

  // pipeline occupancy and advance
  logic                    a_v_q, m_v_q, out_v_q;
  logic [CordicSteps:0]    cv_q;
  logic                    a_take, mul_take, out_take;
  logic [CordicSteps:0]    ck_take;

  always_comb begin
    out_take = !out_v_q | out_ready_i;
    mul_take = !m_v_q | out_take;
  end

  // a stage may advance when any stage from it down to the multiplier holds a bubble
  for (genvar k = 0; k <= CordicSteps; k++) begin : g_take
    assign ck_take[k] = mul_take | !(&cv_q[CordicSteps:k]);
  end

  assign a_take     = !a_v_q | ck_take[0];
  assign in_ready_o = a_take;

  // sequencer
  logic                  in_acc, emit, is_last;
  logic [CountW-1:0]     idx_q, idx_d, idx_eff;
  logic [PHASE_BITS-1:0] acc_q, acc_d, acc_eff;
  logic [AngleW-1:0]     ang_raw, ang_cos;

  assign in_acc  = in_valid_i & a_take;
  assign idx_eff = restart_i ? '0 : idx_q;
  assign acc_eff = restart_i ? off_q : acc_q;
  assign emit    = idx_eff < cnt_q;
  assign is_last = ({1'b0, idx_eff} + (CountW+1)'(1)) == {1'b0, cnt_q};

  always_comb begin
    idx_d = idx_q;
    acc_d = acc_q;
    if (in_acc) begin
      idx_d = idx_eff;
      acc_d = acc_eff;
      if (emit) begin
        idx_d = idx_eff + CountW'(1);
        acc_d = acc_eff + step_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      acc_q <= '0;
    end else begin
      idx_q <= idx_d;
      acc_q <= acc_d;
    end
  end

  if (PHASE_BITS >= AngleW) begin : g_ang_trunc
    assign ang_raw = acc_eff[PHASE_BITS-1 -: AngleW];
  end else begin : g_ang_pad
    assign ang_raw = {acc_eff, {(AngleW-PHASE_BITS){1'b0}}};
  end

  assign ang_cos = ang_raw + (wave_q ? QuarterTurn : '0);

  // phase stage
  logic [AngleW-1:0] ang_q;
  logic              a_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
    end else if (a_take) begin
      a_v_q <= in_acc & emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_take) begin
      ang_q    <= ang_cos;
      a_last_q <= is_last;
    end
  end

  // fold stage: angle into [-1/4, +1/4] turn
  logic signed [XW-1:0] x_q [CordicSteps+1];
  logic signed [XW-1:0] y_q [CordicSteps+1];
  logic signed [ZW-1:0] z_q [CordicSteps+1];
  logic [CordicSteps:0] lst_q;
  logic signed [ZW-1:0] z_fold;

  always_comb begin
    if (ang_q[AngleW-1 -: 2] == 2'd1 || ang_q[AngleW-1 -: 2] == 2'd2) begin
      z_fold = $signed({1'b0, 32'h8000_0000}) - $signed({1'b0, ang_q});
    end else begin
      z_fold = $signed({ang_q[AngleW-1], ang_q});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cv_q[0] <= 1'b0;
    end else if (ck_take[0]) begin
      cv_q[0] <= a_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ck_take[0]) begin
      x_q[0]   <= XW'(CordicX0);
      y_q[0]   <= '0;
      z_q[0]   <= z_fold;
      lst_q[0] <= a_last_q;
    end
  end

  // rotation stages, one step each
  for (genvar i = 0; i < CordicSteps; i++) begin : g_step
    logic signed [XW-1:0] dx, dy;
    logic signed [ZW-1:0] da;

    assign dx = y_q[i] >>> i;
    assign dy = x_q[i] >>> i;
    assign da = ZW'(AtanTurns[i]);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cv_q[i+1] <= 1'b0;
      end else if (ck_take[i+1]) begin
        cv_q[i+1] <= cv_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (ck_take[i+1]) begin
        lst_q[i+1] <= lst_q[i];
        if (!z_q[i][ZW-1]) begin
          x_q[i+1] <= x_q[i] - dx;
          y_q[i+1] <= y_q[i] + dy;
          z_q[i+1] <= z_q[i] - da;
        end else begin
          x_q[i+1] <= x_q[i] + dx;
          y_q[i+1] <= y_q[i] - dy;
          z_q[i+1] <= z_q[i] + da;
        end
      end
    end
  end

  // amplitude multiply
  logic signed [SAMPLE_BITS+XW-1:0] m_q;
  logic                             m_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_v_q <= 1'b0;
    end else if (mul_take) begin
      m_v_q <= cv_q[CordicSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mul_take) begin
      m_q      <= amp_q * y_q[CordicSteps];
      m_last_q <= lst_q[CordicSteps];
    end
  end

  // round, scale, saturate
  logic signed [PW-1:0]          rnd, shf;
  logic signed [SAMPLE_BITS-1:0] sat;

  assign rnd = PW'(m_q) + RoundHalf;
  assign shf = rnd >>> CordicFrac;

  always_comb begin
    if (shf > SatHi) begin
      sat = SatHi[SAMPLE_BITS-1:0];
    end else if (shf < SatLo) begin
      sat = SatLo[SAMPLE_BITS-1:0];
    end else begin
      sat = shf[SAMPLE_BITS-1:0];
    end
  end

  logic signed [SAMPLE_BITS-1:0] sample_q;
  logic                          out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_take) begin
      out_v_q <= m_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_take) begin
      sample_q   <= sat;
      out_last_q <= m_last_q;
    end
  end

  assign out_valid_o = out_v_q;
  assign sample_o    = sample_q;
  assign last_o      = out_last_q;

  // checks
  a_ready_only_on_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_v_q && !out_ready_i)
    else $error("input stalled without a stalled full output");

  a_restart_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && restart_i && cnt_q != '0 |=> a_v_q)
    else $error("restart with nonzero count produced no sample");

  a_index_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !restart_i && (idx_q < cnt_q) |=> idx_q == $past(idx_q) + CountW'(1))
    else $error("sample index did not advance");

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// Testbench for the sine/cosine wave generator: APB setup, restart ticks, CORDIC sample predictor.
`timescale 1ns / 100ps

module tb_top;
  import scwg_pkg::*;

  typedef struct {
    logic signed [15:0] value;
    logic               is_last;
  } wave_point_t;

  // atan(2^-i) in 2^-32 turn units
  localparam longint ArcTurns [28] = '{
    536870912, 316933406, 167458907, 85004757, 42667331, 21354465,
    10679841, 5340245, 2670163, 1335087, 667544, 333772, 166886,
    83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
    81, 41, 20, 10, 5
  };
  localparam longint RotorStartX = 326016436;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               restart_i   = 1'b0;
  logic               out_ready_i = 1'b0;
  logic               psel        = 1'b0;
  logic               penable     = 1'b0;
  logic               pwrite      = 1'b0;
  logic [4:0]         paddr       = '0;
  logic [31:0]        pwdata      = '0;
  logic               in_ready_o;
  logic               out_valid_o;
  logic signed [15:0] sample_o;
  logic               last_o;
  logic [31:0]        prdata;
  logic               pready;

  // predictor copy of registers and sequencer
  logic signed [15:0] gain       = 16'sd32767;
  logic [31:0]        step_cfg   = '0;
  logic [31:0]        offset_cfg = '0;
  logic [23:0]        count_cfg  = '0;
  logic               cosine_sel = 1'b0;
  logic [23:0]        tick_idx   = '0;
  logic [31:0]        phase_acc  = '0;

  bit          restart_queue [$];
  wave_point_t due_points [$];
  int          errors_seen = 0;
  int          send_hold   = 0;
  int          recv_hold   = 0;
  bit          idle_on     = 1'b1;
  bit          squeeze_req = 1'b0;
  logic        squeeze     = 1'b0;

  sine_cosine_wave_generator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .restart_i   (restart_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sample_o    (sample_o),
    .last_o      (last_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #1 clk_i = ~clk_i;

  function automatic logic signed [15:0] wave_value(input logic [31:0] phase);
    logic [31:0] ang;
    longint      x, y, z, dx, dy, prod;
    int          i;
    ang = cosine_sel ? phase + 32'h4000_0000 : phase;
    x = RotorStartX;
    y = 0;
    if (ang[31:30] == 2'd1 || ang[31:30] == 2'd2) begin
      z = 64'sh8000_0000 - longint'(ang);
    end else if (ang[31]) begin
      z = longint'(ang) - 64'sh1_0000_0000;
    end else begin
      z = longint'(ang);
    end
    for (i = 0; i < 28; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - ArcTurns[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + ArcTurns[i];
      end
    end
    prod = (longint'(gain) * y + (64'sd1 <<< 28)) >>> 29;
    if (prod > 32767) return 16'sh7FFF;
    if (prod < -32768) return 16'sh8000;
    return 16'(prod);
  endfunction

  function automatic void take_tick(input logic restart);
    wave_point_t pt;
    if (restart) begin
      tick_idx  = '0;
      phase_acc = offset_cfg;
    end
    if (tick_idx < count_cfg) begin
      pt.value   = wave_value(phase_acc);
      pt.is_last = (25'(tick_idx) + 25'd1 == 25'(count_cfg));
      due_points.push_back(pt);
      tick_idx  = tick_idx + 24'd1;
      phase_acc = phase_acc + step_cfg;
    end
  endfunction

  task automatic apb_write(input reg_idx_e idx, input logic [31:0] word);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= word;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      RegAmplitude:   gain       = word[15:0];
      RegPhaseStep:   step_cfg   = word;
      RegPhaseOffset: offset_cfg = word;
      RegSampleCount: count_cfg  = word[23:0];
      RegWaveSelect:  cosine_sel = word[0];
      default: ;
    endcase
  endtask

  task automatic settle();
    while (restart_queue.size() != 0 || in_valid_i || due_points.size() != 0)
      @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic random_phase(output int n);
    logic [31:0] word;
    int          lim;
    if ($urandom_range(0, 1)) begin
      case ($urandom_range(0, 7))
        0: word = 32'hFFFF_8000;
        1: word = 32'h0000_7FFF;
        default: word = $urandom;
      endcase
      apb_write(RegAmplitude, word);
    end
    if ($urandom_range(0, 1)) begin
      word = $urandom_range(0, 3) == 0 ? 32'hFFFF_FFFF / $urandom_range(2, 64) : $urandom;
      apb_write(RegPhaseStep, word);
    end
    if ($urandom_range(0, 1)) apb_write(RegPhaseOffset, $urandom);
    if ($urandom_range(0, 2) != 0) begin
      word = $urandom;
      case ($urandom_range(0, 19))
        0:       word[23:0] = 24'hFF_FFFF;
        1, 2:    word[23:0] = $urandom_range(49, 24'hFF_FFFF);
        default: word[23:0] = $urandom_range(0, 48);
      endcase
      apb_write(RegSampleCount, word);
    end
    if ($urandom_range(0, 1)) apb_write(RegWaveSelect, $urandom);
    lim = (count_cfg > 60) ? 64 : int'(count_cfg) + 4;
    n = $urandom_range(1, lim);
    restart_queue.push_back($urandom_range(0, 3) != 0);
    repeat (n - 1) restart_queue.push_back($urandom_range(0, 15) == 0);
  endtask

  // input driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) take_tick(restart_i);
      if (!in_valid_i || in_ready_o) begin
        if (send_hold != 0) begin
          send_hold = send_hold - 1;
          in_valid_i <= 1'b0;
        end else if (restart_queue.size() != 0) begin
          in_valid_i <= 1'b1;
          restart_i  <= restart_queue.pop_front();
          if (idle_on && $urandom_range(0, 5) == 0) send_hold = $urandom_range(1, 11);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // output monitor
  always @(posedge clk_i) begin
    wave_point_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (due_points.size() == 0) begin
          $error("unexpected transaction: sample_o %0d last_o %0b", sample_o, last_o);
          errors_seen++;
        end else begin
          want = due_points.pop_front();
          if (sample_o !== want.value) begin
            $error("sample_o: expected %0d, got %0d", want.value, sample_o);
            errors_seen++;
          end
          if (last_o !== want.is_last) begin
            $error("last_o: expected %0b, got %0b", want.is_last, last_o);
            errors_seen++;
          end
        end
      end
      if (squeeze) begin
        out_ready_i <= 1'b0;
      end else if (recv_hold != 0) begin
        recv_hold = recv_hold - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if (idle_on && $urandom_range(0, 7) == 0) recv_hold = $urandom_range(1, 11);
      end
    end
  end

  // long receiver stall to back the pipeline up
  initial begin
    wait (squeeze_req);
    @(posedge clk_i);
    squeeze <= 1'b1;
    repeat (300) @(posedge clk_i);
    squeeze <= 1'b0;
  end

  initial begin
    #1000000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int sent, n;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ticks straight after reset, no restart
    apb_write(RegSampleCount, 32'd3);
    restart_queue = '{1'b0, 1'b0, 1'b0, 1'b0};
    settle();
    // zero count
    apb_write(RegSampleCount, 32'd0);
    restart_queue = '{1'b1, 1'b0};
    settle();
    // -1.0 gain on -1.0 sine saturates positive
    apb_write(RegAmplitude, 32'hFFFF_8000);
    apb_write(RegPhaseStep, 32'h4000_0000);
    apb_write(RegPhaseOffset, 32'hC000_0000);
    apb_write(RegSampleCount, 32'd4);
    apb_write(RegWaveSelect, 32'd0);
    restart_queue = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0};
    settle();
    // raise count after the end, sequence resumes
    apb_write(RegSampleCount, 32'd6);
    restart_queue = '{1'b0, 1'b0, 1'b0};
    settle();
    apb_write(RegAmplitude, 32'h0000_7FFF);
    apb_write(RegWaveSelect, 32'd1);
    apb_write(RegPhaseStep, 32'hFFFF_FFFF);
    apb_write(RegPhaseOffset, 32'hFFFF_FFFF);
    apb_write(RegSampleCount, 32'h00FF_FFFF);
    restart_queue = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b0};
    settle();
    apb_write(RegSampleCount, 32'd1);
    apb_write(RegPhaseStep, 32'h8000_0000);
    restart_queue = '{1'b1, 1'b0, 1'b1};
    settle();

    // backpressure: sender keeps going while the receiver is held off
    apb_write(RegAmplitude, $urandom);
    apb_write(RegPhaseStep, $urandom);
    apb_write(RegSampleCount, 32'd1000);
    squeeze_req = 1'b1;
    restart_queue.push_back(1'b1);
    repeat (159) restart_queue.push_back(1'b0);
    settle();
    sent = 160;

    while (sent < 500) begin
      idle_on = (sent < 420) && ($urandom_range(0, 3) != 0);
      random_phase(n);
      settle();
      sent += n;
    end

    if (errors_seen == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/scwg_pkg.sv
src/sine_cosine_wave_generator.sv
sim/tb_top.sv
